// ----- rtl/core/clt_pkg.sv -----
package clt_pkg;

   localparam int MAX_ARGS = 256;
   localparam logic [7:0] ARG_CAP = (MAX_ARGS - 1 > 255) ? 8'd255 : 8'(MAX_ARGS - 1);

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam int         OCT_SHIFT      = 3;

   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_ARG_END  = 2'd1,
      KIND_LINE_END = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic [7:0] idx;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [SLOT_W-1:0]            count;
   } bundle_type;

   function automatic bundle_type bundle_add(input bundle_type b, input logic [7:0] data_v,
                                             input kind_type kind_v, input logic [7:0] idx_v);
      bundle_type r;
      r = b;
      r.slot[b.count[SLOT_W-1:0]].out_byte = data_v;
      r.slot[b.count[SLOT_W-1:0]].kind     = kind_v;
      r.slot[b.count[SLOT_W-1:0]].idx      = idx_v;
      r.count = b.count + SLOT_W'(1);
      return r;
   endfunction

endpackage

// ----- rtl/core/clt_front.sv -----
module clt_front
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_line_end,
   input  logic       q_full,
   output logic       push,
   output bundle_type push_data
);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       esc_ff, esc_in;
   logic [1:0] odig_ff, odig_in;
   logic [7:0] oval_ff, oval_in;
   logic [7:0] cnt_ff, cnt_in;

   logic       accept;
   logic       in_arg;
   logic       is_ws;
   logic       is_digit;
   logic [7:0] digit_val;
   logic [7:0] oct_next;
   logic [7:0] cnt_inc;
   logic       plain_go;
   bundle_type bundle;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign in_arg    = (mode_ff == MODE_PLAIN) || (mode_ff == MODE_QUOTED);
   assign is_ws     = (req_in_byte == CHAR_SPACE) ||
                      ((req_in_byte >= CHAR_TAB) && (req_in_byte <= CHAR_CR));
   assign is_digit  = (req_in_byte >= CHAR_ZERO) && (req_in_byte <= CHAR_NINE);
   assign digit_val = 8'(req_in_byte - CHAR_ZERO);
   assign oct_next  = 8'(oval_ff << OCT_SHIFT) + digit_val;
   assign cnt_inc   = (cnt_ff < ARG_CAP) ? 8'(cnt_ff + 8'd1) : cnt_ff;

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      odig_in  = odig_ff;
      oval_in  = oval_ff;
      cnt_in   = cnt_ff;
      plain_go = 1'b0;
      bundle   = '0;
      if (req_line_end) begin
         if (in_arg) begin
            if (odig_ff != 2'd0) begin
               bundle = bundle_add(bundle, oval_ff, KIND_BYTE, cnt_ff);
            end
            bundle = bundle_add(bundle, 8'd0, KIND_ARG_END, cnt_ff);
            bundle = bundle_add(bundle, 8'd0, KIND_LINE_END, cnt_inc);
         end else begin
            bundle = bundle_add(bundle, 8'd0, KIND_LINE_END, cnt_ff);
         end
         mode_in = MODE_IDLE;
         esc_in  = 1'b0;
         odig_in = 2'd0;
         oval_in = 8'd0;
         cnt_in  = 8'd0;
      end else if (in_arg) begin
         if (odig_ff != 2'd0) begin
            if (is_digit) begin
               if (odig_ff == 2'd2) begin
                  bundle  = bundle_add(bundle, oct_next, KIND_BYTE, cnt_ff);
                  odig_in = 2'd0;
                  oval_in = 8'd0;
               end else begin
                  odig_in = odig_ff + 2'd1;
                  oval_in = oct_next;
               end
            end else begin
               bundle   = bundle_add(bundle, oval_ff, KIND_BYTE, cnt_ff);
               odig_in  = 2'd0;
               oval_in  = 8'd0;
               plain_go = 1'b1;
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            if (is_digit) begin
               odig_in = 2'd1;
               oval_in = digit_val;
            end else begin
               bundle = bundle_add(bundle, req_in_byte, KIND_BYTE, cnt_ff);
            end
         end else begin
            plain_go = 1'b1;
         end
      end else if (!is_ws) begin
         esc_in  = 1'b0;
         odig_in = 2'd0;
         oval_in = 8'd0;
         if (req_in_byte == CHAR_QUOTE) begin
            mode_in = MODE_QUOTED;
         end else begin
            mode_in  = MODE_PLAIN;
            plain_go = 1'b1;
         end
      end else begin
         mode_in = MODE_IDLE;
      end

      if (plain_go) begin
         if (req_in_byte == CHAR_BACKSLASH) begin
            esc_in = 1'b1;
         end else if ((mode_in == MODE_QUOTED && req_in_byte == CHAR_QUOTE) ||
                      (mode_in == MODE_PLAIN && is_ws)) begin
            bundle  = bundle_add(bundle, 8'd0, KIND_ARG_END, cnt_ff);
            cnt_in  = cnt_inc;
            mode_in = MODE_IDLE;
            esc_in  = 1'b0;
            odig_in = 2'd0;
            oval_in = 8'd0;
         end else begin
            bundle = bundle_add(bundle, req_in_byte, KIND_BYTE, cnt_ff);
         end
      end
   end

   assign push      = accept && (bundle.count != '0);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         esc_ff  <= 1'b0;
         odig_ff <= 2'd0;
         oval_ff <= 8'd0;
         cnt_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         odig_ff <= odig_in;
         oval_ff <= oval_in;
         cnt_ff  <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_line_end |=> mode_ff == MODE_IDLE && cnt_ff == 8'd0 && !esc_ff)
      else $error("state not cleared after line end");

   a_escape_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(esc_ff && odig_ff != 2'd0) && odig_ff != 2'd3)
      else $error("escape state inconsistent");

   a_idle_no_escape: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> !esc_ff && odig_ff == 2'd0)
      else $error("escape pending between arguments");
`endif

endmodule

// ----- rtl/core/clt_queue.sv -----
module clt_queue
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head,
   output logic       empty
);

   bundle_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff;
   logic [QPTR_W-1:0]       rd_ptr_ff;
   logic [QCNT_W-1:0]       count_ff;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + QPTR_W'(1));
   endfunction

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count lost a write");
`endif

endmodule

// ----- rtl/core/clt_back.sv -----
module clt_back
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_arg_index,
   output logic       rsp_last_of_run
);

   logic              rsp_valid_ff;
   result_type        res_ff;
   logic              last_ff;
   logic [SLOT_W-1:0] sel_ff;

   logic              load;
   logic              is_last;

   assign load    = !empty && (!rsp_valid_ff || rsp_ready);
   assign is_last = (sel_ff == SLOT_W'(head.count - SLOT_W'(1)));
   assign pop     = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sel_ff       <= is_last ? '0 : SLOT_W'(sel_ff + SLOT_W'(1));
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.slot[sel_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = res_ff.out_byte;
   assign rsp_result_kind = res_ff.kind;
   assign rsp_arg_index   = res_ff.idx;
   assign rsp_last_of_run = last_ff;

`ifndef ASSERT_OFF
   a_sel_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> sel_ff < head.count)
      else $error("slot select beyond bundle");

   a_line_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.kind == KIND_LINE_END |-> last_ff)
      else $error("line end word not marked last");

   a_sel_resets_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> sel_ff == '0)
      else $error("slot select not rewound after pop");
`endif

endmodule

// ----- rtl/core/command_line_tokenizer_top.sv -----
// Splits a command line, presented one byte per word with a line-end flag on the last
// word, into argument bytes, argument-end markers and a line-end marker, each tagged
// with its argument index and a flag on the last result of its input word. An input
// word can be accepted every cycle while the queue is not full: the tokenizer front
// end updates its scan state on each accepted word and hands the up to three results
// of a word to a two-entry queue, from which the output stage sends one result per
// cycle while the receiver is ready, through a registered output. A result is held in
// the queue entry and then the output register. The sustained rate is one input word
// per cycle while each gives at most one result and the receiver is ready; a word with
// several results holds the output until all are sent; when the queue fills, input stalls.
module command_line_tokenizer_top
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_arg_index,
   output logic       rsp_last_of_run
);

   logic       q_full;
   logic       q_empty;
   logic       q_push;
   logic       q_pop;
   bundle_type q_push_data;
   bundle_type q_head;

   clt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_line_end (req_line_end),
      .q_full       (q_full),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   clt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   clt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .empty           (q_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_result_kind (rsp_result_kind),
      .rsp_arg_index   (rsp_arg_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- tb/command_line_tokenizer_top_tb.sv -----
module command_line_tokenizer_top_tb;
   import clt_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      SCAN_IDLE   = 2'd0,
      SCAN_BARE   = 2'd1,
      SCAN_QUOTED = 2'd2
   } scan_type;

   typedef struct {
      logic [7:0] in_byte;
      logic       line_end;
   } line_word_type;

   typedef struct {
      logic [7:0] out_byte;
      kind_type   kind;
      logic [7:0] idx;
      logic       last;
   } token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_arg_index;
   logic       rsp_last_of_run;

   line_word_type pending_words[$];
   line_word_type driver_word;
   token_type     expected_tokens[$];
   token_type     word_results[$];
   token_type     seen_token;

   scan_type   tok_mode = SCAN_IDLE;
   logic       tok_escape = 1'b0;
   logic [1:0] tok_oct_count = 2'd0;
   logic [7:0] tok_oct_value = 8'd0;
   logic [7:0] tok_arg = 8'd0;

   int words_total = 0;
   int words_sent = 0;
   int mismatches = 0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_gap = 0;
   int recv_calm = 0;
   int idle_cycles = 0;

   command_line_tokenizer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_line_end(req_line_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_result_kind(rsp_result_kind),
      .rsp_arg_index(rsp_arg_index),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit is_space(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic void emit(input logic [7:0] data, input kind_type kind);
      token_type t;
      t.out_byte = data;
      t.kind = kind;
      t.idx = tok_arg;
      t.last = 1'b0;
      word_results.push_back(t);
   endfunction

   function automatic void close_argument();
      emit(8'h00, KIND_ARG_END);
      if (tok_arg < ARG_CAP) tok_arg = tok_arg + 8'd1;
      tok_mode = SCAN_IDLE;
      tok_escape = 1'b0;
      tok_oct_count = 2'd0;
      tok_oct_value = 8'd0;
   endfunction

   function automatic void plain_byte(input logic [7:0] b);
      if (b == CHAR_BACKSLASH) begin
         tok_escape = 1'b1;
      end else if (tok_mode == SCAN_QUOTED && b == CHAR_QUOTE) begin
         close_argument();
      end else if (tok_mode == SCAN_BARE && is_space(b)) begin
         close_argument();
      end else begin
         emit(b, KIND_BYTE);
      end
   endfunction

   function automatic void predict_word(input logic [7:0] b, input logic eol);
      token_type t;
      word_results.delete();
      if (eol) begin
         if (tok_mode == SCAN_BARE || tok_mode == SCAN_QUOTED) begin
            if (tok_oct_count != 2'd0) emit(tok_oct_value, KIND_BYTE);
            close_argument();
         end
         emit(8'h00, KIND_LINE_END);
         tok_mode = SCAN_IDLE;
         tok_escape = 1'b0;
         tok_oct_count = 2'd0;
         tok_oct_value = 8'd0;
         tok_arg = 8'd0;
      end else if (tok_mode == SCAN_BARE || tok_mode == SCAN_QUOTED) begin
         if (tok_oct_count != 2'd0) begin
            if (is_digit(b)) begin
               tok_oct_value = (tok_oct_value << OCT_SHIFT) + (b - CHAR_ZERO);
               tok_oct_count = tok_oct_count + 2'd1;
               if (tok_oct_count == 2'd3) begin
                  emit(tok_oct_value, KIND_BYTE);
                  tok_oct_count = 2'd0;
                  tok_oct_value = 8'd0;
               end
            end else begin
               emit(tok_oct_value, KIND_BYTE);
               tok_oct_count = 2'd0;
               tok_oct_value = 8'd0;
               plain_byte(b);
            end
         end else if (tok_escape) begin
            tok_escape = 1'b0;
            if (is_digit(b)) begin
               tok_oct_count = 2'd1;
               tok_oct_value = b - CHAR_ZERO;
            end else begin
               emit(b, KIND_BYTE);
            end
         end else begin
            plain_byte(b);
         end
      end else begin
         tok_mode = SCAN_IDLE;
         if (!is_space(b)) begin
            tok_escape = 1'b0;
            tok_oct_count = 2'd0;
            tok_oct_value = 8'd0;
            if (b == CHAR_QUOTE) begin
               tok_mode = SCAN_QUOTED;
            end else begin
               tok_mode = SCAN_BARE;
               plain_byte(b);
            end
         end
      end
      if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
      foreach (word_results[i]) begin
         t = word_results[i];
         expected_tokens.push_back(t);
      end
   endfunction

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic push_word(input logic [7:0] b, input logic eol);
      line_word_type w;
      w.in_byte = b;
      w.line_end = eol;
      pending_words.push_back(w);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
   endtask

   task automatic push_spaces();
      int n;
      int r;
      n = $urandom_range(1, 3);
      repeat (n) begin
         r = $urandom_range(0, 5);
         push_word((r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r), 1'b0);
      end
   endtask

   task automatic add_random_line();
      int n_args;
      int len;
      int r;
      int d;
      bit quoted;
      n_args = $urandom_range(0, 6);
      for (int a = 0; a < n_args; a++) begin
         if (a > 0 || $urandom_range(0, 2) == 0) push_spaces();
         quoted = ($urandom_range(0, 3) == 0);
         if (quoted) push_word(CHAR_QUOTE, 1'b0);
         len = $urandom_range(1, 5);
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            case (r)
               0: begin
                  push_word(CHAR_BACKSLASH, 1'b0);
                  push_word(8'($urandom_range(0, 255)), 1'b0);
               end
               1: begin
                  push_word(CHAR_BACKSLASH, 1'b0);
                  d = $urandom_range(1, 3);
                  repeat (d) push_word(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
               end
               2: push_word(8'($urandom_range(0, 255)), 1'b0);
               3: push_word(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
               default: push_word(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
            endcase
         end
         if (quoted && $urandom_range(0, 4) != 0) push_word(CHAR_QUOTE, 1'b0);
      end
      if ($urandom_range(0, 2) == 0) push_spaces();
      push_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_in_byte, req_line_end);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               driver_word = pending_words.pop_front();
               req_in_byte <= driver_word.in_byte;
               req_line_end <= driver_word.line_end;
               req_valid <= 1'b1;
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            recv_gap = pick_gap(recv_calm);
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected word: byte %0d kind %0d index %0d last %0d",
                           rsp_out_byte, rsp_result_kind, rsp_arg_index, rsp_last_of_run);
            end else begin
               seen_token = expected_tokens.pop_front();
               if (rsp_out_byte !== seen_token.out_byte || rsp_result_kind !== seen_token.kind ||
                   rsp_arg_index !== seen_token.idx || rsp_last_of_run !== seen_token.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch byte/kind/index/last: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                              seen_token.out_byte, seen_token.kind, seen_token.idx,
                              seen_token.last, rsp_out_byte, rsp_result_kind,
                              rsp_arg_index, rsp_last_of_run);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("command_line_tokenizer_top_tb failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      push_word(CHAR_SPACE, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(CHAR_CR, 1'b0);
      push_text("\"q\\\"\"z\"");
      push_text(" \\123\\7A\\5 ");
      push_word(8'hFF, 1'b1);
      push_text("x\\");
      push_word(8'h00, 1'b1);
      push_text("\"\\4");
      push_word(8'h5A, 1'b1);
      push_word(8'h00, 1'b1);

      while (pending_words.size() < 160) add_random_line();
      words_total = pending_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (words_sent == words_total && expected_tokens.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("command_line_tokenizer_top_tb passed");
      end else begin
         $display("command_line_tokenizer_top_tb failed");
      end
      $finish;
   end

endmodule
